>>> design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and item types of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int MAX_BATCH  = 64;
    localparam int WORD_W     = 64;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_W);

    localparam int BLK_W   = 12;
    localparam int CNT_W   = 13;
    localparam int BATCH_W = 7;

    localparam logic [CNT_W-1:0] BLOCKS_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] LIMIT_MAX    = CNT_W'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_TEST  = 2'd2,
        FN_BATCH = 2'd3
    } bba_func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } bba_status_t;

    typedef struct packed {
        bba_func_t            func;
        logic [BLK_W-1:0]     target_block;
        logic [BATCH_W-1:0]   batch_count;
    } bba_req_t;

    typedef struct packed {
        bba_status_t          status;
        logic [BLK_W-1:0]     granted_block;
        logic                 is_allocated;
        logic [CNT_W-1:0]     free_count;
        logic                 last;
    } bba_rsp_t;

    typedef struct packed {
        logic                 clear;
        logic                 rd_en;
        logic [WIDX_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [WIDX_W-1:0]    wr_addr;
        logic [WORD_W-1:0]    wr_data;
    } bba_mem_ctl_t;

    // lowest clear bit of a word
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> design/bba_map_store.sv
// ----------------------------------------------------------------------------
// bba_map_store
// Allocation bitmap words in a synchronous RAM with a registered read.
// Per-row valid flops make a cleared map at once; invalid rows read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_store import bba_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bba_mem_ctl_t        ctl,
    output logic [WORD_W-1:0]        rd_word
);

    logic [WORD_W-1:0]    mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_valid_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (ctl.clear) begin
                row_valid_reg <= '0;
            end else if (ctl.wr_en) begin
                row_valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= row_valid_reg[ctl.rd_addr] && !ctl.clear;
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> design/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a 4096-bit map held as 64 words of 64 bits.
// Allocate, free, test and batch allocate; every result carries the free count.
//
//   channel | ports                          | payload
//   --------+--------------------------------+---------------------------
//   request | s_valid / s_ready / s_item     | bba_req_t (func, id, count)
//   result  | m_valid / m_ready / m_item     | bba_rsp_t (per grant or request)
//   config  | cfg_we / cfg_wdata             | blocks_in_use, 13 bits
//
// One item at a time. Free and test pass through S_LOOK and S_RESP; rejected
// requests go straight to S_RESP. Allocate reads map words in order from word 0,
// one per cycle while it passes full words (at most 63), and grants each block
// at the lowest clear bit of the current word; a batch of n grants n blocks.
// Reset or a config write clears the map at once through per-row valid flops.
// A stalled result port holds the scan before each grant; the next request is taken
// while the last result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator import bba_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bba_req_t          s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bba_rsp_t               m_item
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SCAN = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] n);
        return (n > LIMIT_MAX) ? LIMIT_MAX : n;
    endfunction

    state_t               state_reg, state_next;
    bba_req_t             req_reg, req_next;
    bba_rsp_t             rsp_reg, rsp_next;
    logic [BATCH_W-1:0]   cnt_left_reg, cnt_left_next;
    logic [WIDX_W-1:0]    word_idx_reg, word_idx_next;
    logic [WORD_W-1:0]    work_reg, work_next;
    logic                 fresh_reg, fresh_next;
    logic                 dirty_reg, dirty_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [CNT_W-1:0]     blocks_reg, blocks_next;
    logic                 m_valid_reg;
    bba_rsp_t             m_item_reg;

    bba_mem_ctl_t         mem_ctl;
    logic [WORD_W-1:0]    rd_word;
    logic [CNT_W-1:0]     lim;
    logic                 out_free;
    logic [WORD_W-1:0]    cur_word;
    logic [BIT_W-1:0]     zero_bit;
    logic                 word_full;
    logic [WORD_W-1:0]    granted_word;
    logic [BLK_W-1:0]     granted_blk;
    logic [BIT_W-1:0]     id_bit;
    logic                 id_hit;
    logic                 emit;
    bba_rsp_t             emit_item;

    bba_map_store u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .rd_word (rd_word)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        lim          = eff_limit(blocks_reg);
        out_free     = !m_valid_reg || m_ready;
        cur_word     = fresh_reg ? rd_word : work_reg;
        zero_bit     = first_zero(cur_word);
        word_full    = &cur_word;
        granted_word = cur_word | ({{(WORD_W-1){1'b0}}, 1'b1} << zero_bit);
        granted_blk  = BLK_W'({word_idx_reg, zero_bit});
        id_bit       = req_reg.target_block[BIT_W-1:0];
        id_hit       = rd_word[id_bit];

        state_next    = state_reg;
        req_next      = req_reg;
        rsp_next      = rsp_reg;
        cnt_left_next = cnt_left_reg;
        word_idx_next = word_idx_reg;
        work_next     = work_reg;
        fresh_next    = fresh_reg;
        dirty_next    = dirty_reg;
        free_next     = free_reg;
        blocks_next   = blocks_reg;
        mem_ctl       = '0;
        emit          = 1'b0;
        emit_item     = rsp_reg;
        emit_item.free_count = free_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next               = s_item;
                    word_idx_next          = '0;
                    fresh_next             = 1'b1;
                    dirty_next             = 1'b0;
                    rsp_next.status        = ST_INVALID;
                    rsp_next.granted_block = '0;
                    rsp_next.is_allocated  = 1'b0;
                    rsp_next.free_count    = '0;
                    rsp_next.last          = 1'b1;
                    case (s_item.func)
                        FN_ALLOC: begin
                            if (free_reg == '0) begin
                                rsp_next.status = ST_FULL;
                                state_next      = S_RESP;
                            end else begin
                                cnt_left_next   = BATCH_W'(1);
                                free_next       = free_reg - CNT_W'(1);
                                mem_ctl.rd_en   = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        FN_BATCH: begin
                            if (s_item.batch_count == '0 ||
                                s_item.batch_count > BATCH_W'(MAX_BATCH)) begin
                                state_next      = S_RESP;
                            end else if (free_reg < CNT_W'(s_item.batch_count)) begin
                                rsp_next.status = ST_FULL;
                                state_next      = S_RESP;
                            end else begin
                                cnt_left_next   = s_item.batch_count;
                                free_next       = free_reg - CNT_W'(s_item.batch_count);
                                mem_ctl.rd_en   = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        default: begin
                            if ({1'b0, s_item.target_block} >= lim) begin
                                state_next      = S_RESP;
                            end else begin
                                mem_ctl.rd_en   = 1'b1;
                                mem_ctl.rd_addr = s_item.target_block[BIT_W +: WIDX_W];
                                state_next      = S_LOOK;
                            end
                        end
                    endcase
                end
            end
            S_LOOK: begin
                state_next = S_RESP;
                if (req_reg.func == FN_TEST) begin
                    rsp_next.status       = ST_OK;
                    rsp_next.is_allocated = id_hit;
                end else if (id_hit) begin
                    rsp_next.status = ST_OK;
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_addr = req_reg.target_block[BIT_W +: WIDX_W];
                    mem_ctl.wr_data = rd_word & ~({{(WORD_W-1){1'b0}}, 1'b1} << id_bit);
                    free_next       = free_reg + CNT_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                work_next  = cur_word;
                fresh_next = 1'b0;
                if (word_full) begin
                    // move on; write back a word filled by this request
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = word_idx_reg + WIDX_W'(1);
                    mem_ctl.wr_en   = dirty_reg;
                    mem_ctl.wr_addr = word_idx_reg;
                    mem_ctl.wr_data = cur_word;
                    word_idx_next   = word_idx_reg + WIDX_W'(1);
                    fresh_next      = 1'b1;
                    dirty_next      = 1'b0;
                end else if (out_free) begin
                    emit                    = 1'b1;
                    emit_item.status        = ST_OK;
                    emit_item.granted_block = granted_blk;
                    emit_item.is_allocated  = 1'b0;
                    emit_item.last          = (cnt_left_reg == BATCH_W'(1));
                    work_next               = granted_word;
                    dirty_next              = 1'b1;
                    cnt_left_next           = cnt_left_reg - BATCH_W'(1);
                    if (cnt_left_reg == BATCH_W'(1)) begin
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_addr = word_idx_reg;
                        mem_ctl.wr_data = granted_word;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            blocks_next   = cfg_wdata;
            free_next     = eff_limit(cfg_wdata);
            mem_ctl.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            free_reg    <= eff_limit(BLOCKS_RESET);
            blocks_reg  <= BLOCKS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            blocks_reg <= blocks_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        cnt_left_reg <= cnt_left_next;
        word_idx_reg <= word_idx_next;
        work_reg     <= work_next;
        fresh_reg    <= fresh_next;
        dirty_reg    <= dirty_next;
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

    a_free_le_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= lim)
        else $error("free count above block limit");

    a_scan_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && word_full) |-> word_idx_reg != WIDX_W'(MAP_WORDS - 1))
        else $error("scan ran past the last map word");

    a_grant_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && emit) |-> {1'b0, granted_blk} < lim)
        else $error("granted block beyond limit");

    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> cnt_left_reg != '0)
        else $error("scan with no blocks left to grant");

    a_last_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && emit && emit_item.last) |=> state_reg == S_IDLE)
        else $error("scan continued after final grant");

endmodule

`default_nettype wire
